// ===== rtl/ssi_pkg.sv =====
// Shared constants and types for the segment against sphere hit test.
`timescale 1ns / 1ps

package ssi_pkg;

   // Default coordinate width in bits.
   localparam int COORD_WIDTH_DEFAULT = 16;

   // Number of register stages from the input word to the result word.
   localparam int STAGE_COUNT = 8;

   // Early decision taken once the distances are known.
   typedef struct packed {
      logic settled;
      logic hit;
   } verdict_type;

endpackage

// ===== rtl/segment_sphere_intersection.sv =====
// Pipelined segment against sphere hit test, exact integer arithmetic.
// Throughput: one word per cycle while req_ready is high; eight register stages, each with its own valid bit.
// A stalled result holds its stage; the stages below keep filling their bubbles.
// Reset clears the valid bits only; the data registers are not reset.
`timescale 1ns / 1ps

module segment_sphere_intersection
   import ssi_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COORD_WIDTH-1:0] req_seg_start_x,
   input  logic [COORD_WIDTH-1:0] req_seg_start_y,
   input  logic [COORD_WIDTH-1:0] req_seg_start_z,
   input  logic [COORD_WIDTH-1:0] req_seg_end_x,
   input  logic [COORD_WIDTH-1:0] req_seg_end_y,
   input  logic [COORD_WIDTH-1:0] req_seg_end_z,
   input  logic [COORD_WIDTH-1:0] req_center_x,
   input  logic [COORD_WIDTH-1:0] req_center_y,
   input  logic [COORD_WIDTH-1:0] req_center_z,
   input  logic [COORD_WIDTH-1:0] req_radius,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_hit
);

   localparam int W    = COORD_WIDTH;
   localparam int DW   = W + 1;        // coordinate difference, signed
   localparam int SQW  = 2 * W;        // square of one difference
   localparam int PW   = 2 * W + 2;    // product of two differences, signed
   localparam int DSW  = 2 * W + 2;    // squared distance
   localparam int CSW  = 2 * W + 3;    // cross product component, signed
   localparam int CMW  = 2 * W + 2;    // cross component magnitude
   localparam int HW   = W + 1;        // half of a magnitude for split multiply
   localparam int PPW  = 2 * HW;       // partial product of two halves
   localparam int SQM  = 2 * CMW;      // square of a cross component
   localparam int RPW  = W + HW;       // partial product of radius^2 and length^2
   localparam int PRW  = 4 * W + 2;    // radius^2 times length^2
   localparam int CRW  = SQM + 2;      // squared cross product length

   // Stage handshake
   logic [STAGE_COUNT:1] vld_ff;
   logic [STAGE_COUNT:1] stage_en;

   always_comb begin
      stage_en[STAGE_COUNT] = !vld_ff[STAGE_COUNT] || rsp_ready;
      for (int i = STAGE_COUNT - 1; i >= 1; i--) begin
         stage_en[i] = !vld_ff[i] || stage_en[i + 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_en[1]) begin
            vld_ff[1] <= req_valid;
         end
         for (int i = 2; i <= STAGE_COUNT; i++) begin
            if (stage_en[i]) begin
               vld_ff[i] <= vld_ff[i - 1];
            end
         end
      end
   end

   assign req_ready = stage_en[1];
   assign rsp_valid = vld_ff[STAGE_COUNT];

   // Stage 1: differences against the centre and along the segment
   logic [W-1:0]  p1 [3];
   logic [W-1:0]  p2 [3];
   logic [W-1:0]  ctr [3];
   logic [DW-1:0] s1_v_in [3];
   logic [DW-1:0] s1_w_in [3];
   logic [DW-1:0] s1_e_in [3];
   logic          s1_same_in;

   logic [DW-1:0] s1_v_ff [3];
   logic [DW-1:0] s1_w_ff [3];
   logic [DW-1:0] s1_e_ff [3];
   logic [W-1:0]  s1_r_ff;
   logic          s1_same_ff;

   always_comb begin
      p1[0]  = req_seg_start_x;
      p1[1]  = req_seg_start_y;
      p1[2]  = req_seg_start_z;
      p2[0]  = req_seg_end_x;
      p2[1]  = req_seg_end_y;
      p2[2]  = req_seg_end_z;
      ctr[0] = req_center_x;
      ctr[1] = req_center_y;
      ctr[2] = req_center_z;
      for (int k = 0; k < 3; k++) begin
         s1_v_in[k] = {p1[k][W-1], p1[k]} - {ctr[k][W-1], ctr[k]};
         s1_w_in[k] = {p2[k][W-1], p2[k]} - {ctr[k][W-1], ctr[k]};
         s1_e_in[k] = {p2[k][W-1], p2[k]} - {p1[k][W-1], p1[k]};
      end
      s1_same_in = (p1[0] == p2[0]) && (p1[1] == p2[1]) && (p1[2] == p2[2]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         for (int k = 0; k < 3; k++) begin
            s1_v_ff[k] <= s1_v_in[k];
            s1_w_ff[k] <= s1_w_in[k];
            s1_e_ff[k] <= s1_e_in[k];
         end
         s1_r_ff    <= req_radius;
         s1_same_ff <= s1_same_in;
      end
   end

   // Stage 2: squares, cross product terms and radius squared
   logic signed [PW-1:0] s2_vv [3];
   logic signed [PW-1:0] s2_ww [3];
   logic signed [PW-1:0] s2_ee [3];
   logic signed [PW-1:0] s2_pa_in [3];
   logic signed [PW-1:0] s2_pb_in [3];

   logic [SQW-1:0]       s2_sqv_ff [3];
   logic [SQW-1:0]       s2_sqw_ff [3];
   logic [SQW-1:0]       s2_sqe_ff [3];
   logic signed [PW-1:0] s2_pa_ff [3];
   logic signed [PW-1:0] s2_pb_ff [3];
   logic [SQW-1:0]       s2_r2_ff;
   logic                 s2_same_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s2_vv[k] = $signed(s1_v_ff[k]) * $signed(s1_v_ff[k]);
         s2_ww[k] = $signed(s1_w_ff[k]) * $signed(s1_w_ff[k]);
         s2_ee[k] = $signed(s1_e_ff[k]) * $signed(s1_e_ff[k]);
      end
      // cross = v x w, component k = pa - pb
      s2_pa_in[0] = $signed(s1_v_ff[1]) * $signed(s1_w_ff[2]);
      s2_pb_in[0] = $signed(s1_w_ff[1]) * $signed(s1_v_ff[2]);
      s2_pa_in[1] = $signed(s1_w_ff[0]) * $signed(s1_v_ff[2]);
      s2_pb_in[1] = $signed(s1_v_ff[0]) * $signed(s1_w_ff[2]);
      s2_pa_in[2] = $signed(s1_v_ff[0]) * $signed(s1_w_ff[1]);
      s2_pb_in[2] = $signed(s1_w_ff[0]) * $signed(s1_v_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         for (int k = 0; k < 3; k++) begin
            s2_sqv_ff[k] <= s2_vv[k][SQW-1:0];
            s2_sqw_ff[k] <= s2_ww[k][SQW-1:0];
            s2_sqe_ff[k] <= s2_ee[k][SQW-1:0];
            s2_pa_ff[k]  <= s2_pa_in[k];
            s2_pb_ff[k]  <= s2_pb_in[k];
         end
         s2_r2_ff   <= SQW'(s1_r_ff) * SQW'(s1_r_ff);
         s2_same_ff <= s1_same_ff;
      end
   end

   // Stage 3: squared distances and signed cross components
   logic [DSW-1:0]        s3_d1_ff;
   logic [DSW-1:0]        s3_d2_ff;
   logic [DSW-1:0]        s3_dl_ff;
   logic signed [CSW-1:0] s3_cr_ff [3];
   logic [SQW-1:0]        s3_r2_ff;
   logic                  s3_same_ff;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s3_d1_ff <= DSW'(s2_sqv_ff[0]) + DSW'(s2_sqv_ff[1]) + DSW'(s2_sqv_ff[2]);
         s3_d2_ff <= DSW'(s2_sqw_ff[0]) + DSW'(s2_sqw_ff[1]) + DSW'(s2_sqw_ff[2]);
         s3_dl_ff <= DSW'(s2_sqe_ff[0]) + DSW'(s2_sqe_ff[1]) + DSW'(s2_sqe_ff[2]);
         for (int k = 0; k < 3; k++) begin
            s3_cr_ff[k] <= CSW'(s2_pa_ff[k]) - CSW'(s2_pb_ff[k]);
         end
         s3_r2_ff   <= s2_r2_ff;
         s3_same_ff <= s2_same_ff;
      end
   end

   // Stage 4: endpoint and angle tests, cross magnitudes
   logic           s4_in1;
   logic           s4_in2;
   logic           s4_acute1;
   logic           s4_acute2;
   logic           s4_point;
   verdict_type    s4_verdict_in;
   logic [CSW-1:0] s4_neg [3];
   logic [CMW-1:0] s4_mag_in [3];

   verdict_type    s4_verdict_ff;
   logic [CMW-1:0] s4_mag_ff [3];
   logic [SQW-1:0] s4_r2_ff;
   logic [DSW-1:0] s4_dl_ff;

   always_comb begin
      s4_in1    = s3_d1_ff < DSW'(s3_r2_ff);
      s4_in2    = s3_d2_ff < DSW'(s3_r2_ff);
      s4_point  = s3_d1_ff <= DSW'(s3_r2_ff);
      s4_acute1 = ((DSW + 1)'(s3_d1_ff) + (DSW + 1)'(s3_dl_ff)) > (DSW + 1)'(s3_d2_ff);
      s4_acute2 = ((DSW + 1)'(s3_d2_ff) + (DSW + 1)'(s3_dl_ff)) > (DSW + 1)'(s3_d1_ff);
      if (s3_same_ff) begin
         // coincident endpoints: plain point test
         s4_verdict_in = '{settled: 1'b1, hit: s4_point};
      end else if (s4_in1 || s4_in2) begin
         s4_verdict_in = '{settled: 1'b1, hit: 1'b1};
      end else if (!s4_acute1 || !s4_acute2) begin
         s4_verdict_in = '{settled: 1'b1, hit: 1'b0};
      end else begin
         // leave the decision to the perpendicular distance test
         s4_verdict_in = '{settled: 1'b0, hit: 1'b0};
      end
      for (int k = 0; k < 3; k++) begin
         s4_neg[k]    = -s3_cr_ff[k];
         s4_mag_in[k] = s3_cr_ff[k][CSW-1] ? s4_neg[k][CMW-1:0] : s3_cr_ff[k][CMW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s4_verdict_ff <= s4_verdict_in;
         for (int k = 0; k < 3; k++) begin
            s4_mag_ff[k] <= s4_mag_in[k];
         end
         s4_r2_ff <= s3_r2_ff;
         s4_dl_ff <= s3_dl_ff;
      end
   end

   // Stage 5: split partial products of the cross magnitude squares and of radius^2 times length^2
   logic [PPW-1:0] s5_hh_ff [3];
   logic [PPW-1:0] s5_hl_ff [3];
   logic [PPW-1:0] s5_ll_ff [3];
   logic [RPW-1:0] s5_rhh_ff;
   logic [RPW-1:0] s5_rhl_ff;
   logic [RPW-1:0] s5_rlh_ff;
   logic [RPW-1:0] s5_rll_ff;
   verdict_type    s5_verdict_ff;

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         for (int k = 0; k < 3; k++) begin
            s5_hh_ff[k] <= PPW'(s4_mag_ff[k][CMW-1:HW]) * PPW'(s4_mag_ff[k][CMW-1:HW]);
            s5_hl_ff[k] <= PPW'(s4_mag_ff[k][CMW-1:HW]) * PPW'(s4_mag_ff[k][HW-1:0]);
            s5_ll_ff[k] <= PPW'(s4_mag_ff[k][HW-1:0]) * PPW'(s4_mag_ff[k][HW-1:0]);
         end
         s5_rhh_ff     <= RPW'(s4_r2_ff[SQW-1:W]) * RPW'(s4_dl_ff[DSW-1:HW]);
         s5_rhl_ff     <= RPW'(s4_r2_ff[SQW-1:W]) * RPW'(s4_dl_ff[HW-1:0]);
         s5_rlh_ff     <= RPW'(s4_r2_ff[W-1:0]) * RPW'(s4_dl_ff[DSW-1:HW]);
         s5_rll_ff     <= RPW'(s4_r2_ff[W-1:0]) * RPW'(s4_dl_ff[HW-1:0]);
         s5_verdict_ff <= s4_verdict_ff;
      end
   end

   // Stage 6: recombine partial products
   logic [SQM-1:0] s6_sq_ff [3];
   logic [PRW-1:0] s6_prod_ff;
   verdict_type    s6_verdict_ff;

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         for (int k = 0; k < 3; k++) begin
            s6_sq_ff[k] <= (SQM'(s5_hh_ff[k]) << (2 * HW))
                         + (SQM'(s5_hl_ff[k]) << (HW + 1))
                         + SQM'(s5_ll_ff[k]);
         end
         s6_prod_ff <= (PRW'(s5_rhh_ff) << (W + HW))
                     + (PRW'(s5_rhl_ff) << W)
                     + (PRW'(s5_rlh_ff) << HW)
                     + PRW'(s5_rll_ff);
         s6_verdict_ff <= s5_verdict_ff;
      end
   end

   // Stage 7: squared cross length
   logic [CRW-1:0] s7_cr2_ff;
   logic [PRW-1:0] s7_prod_ff;
   verdict_type    s7_verdict_ff;

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         s7_cr2_ff     <= CRW'(s6_sq_ff[0]) + CRW'(s6_sq_ff[1]) + CRW'(s6_sq_ff[2]);
         s7_prod_ff    <= s6_prod_ff;
         s7_verdict_ff <= s6_verdict_ff;
      end
   end

   // Stage 8: final compare into the result word
   logic s8_hit_ff;

   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         s8_hit_ff <= s7_verdict_ff.settled ? s7_verdict_ff.hit
                                            : (s7_cr2_ff < CRW'(s7_prod_ff));
      end
   end

   assign rsp_hit = s8_hit_ff;

`ifndef SYNTHESIS
   // a full pipe whose result is held must refuse a new word
   assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_ready) |-> !req_ready)
      else $error("request taken while every stage is held");

   // an accepted word lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[1])
      else $error("accepted word lost at the first stage");

   // coincident endpoints always settle on the point test
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[3] && s3_same_ff) |-> s4_verdict_in.settled)
      else $error("coincident endpoints left unsettled");
`endif

endmodule
